// File: rtl/dual_mode_command_deframer_defines.svh
// Assertion macros shared by the deframer modules.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef DUAL_MODE_COMMAND_DEFRAMER_DEFINES_SVH
`define DUAL_MODE_COMMAND_DEFRAMER_DEFINES_SVH

// Check that a condition implies another in the same cycle.
`define DMCD_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition implies another in the next cycle.
`define DMCD_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Check that a condition never holds.
`define DMCD_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

// File: rtl/dmcd_pkg.sv
// Shared types and constants of the dual-mode command deframer.
// No dependencies; every module file imports this package.
package dmcd_pkg;

    // Parameter defaults
    localparam int BINARY_FRAME_BYTES_DEF = 10;
    localparam int LINE_BUFFER_BYTES_DEF  = 64;

    // Field widths
    localparam int BYTE_W       = 8;
    localparam int POS_W        = 6;
    localparam int IDLE_W       = 16;
    localparam int CFG_DATA_W   = 16;
    // Covers the longest frame with the default parameters
    localparam int DESC_LEN_W   = 8;
    localparam int QUEUE_DEPTH  = 2;

    // Register reset values
    localparam logic [BYTE_W-1:0] PACKET_ID_RST  = 8'd5;
    localparam logic [IDLE_W-1:0] IDLE_TICKS_RST = 16'd10;

    // Line terminators
    localparam logic [BYTE_W-1:0] CHAR_CR = 8'h0D;
    localparam logic [BYTE_W-1:0] CHAR_LF = 8'h0A;

    typedef enum logic [0:0] {
        CFG_PACKET_ID  = 1'b0,
        CFG_IDLE_TICKS = 1'b1
    } cfg_index_t;

    typedef enum logic [0:0] {
        OP_BYTE = 1'b0,
        OP_TICK = 1'b1
    } opcode_t;

    typedef enum logic [1:0] {
        KIND_FULL    = 2'd0,
        KIND_TIMEOUT = 2'd1,
        KIND_LINE    = 2'd2,
        KIND_DISCARD = 2'd3
    } frame_kind_t;

    typedef struct packed {
        opcode_t             opcode;
        logic [BYTE_W-1:0]   rx_byte;
    } item_t;

    typedef struct packed {
        frame_kind_t         frame_kind;
        logic [BYTE_W-1:0]   frame_byte;
        logic [POS_W-1:0]    byte_position;
        logic                last_byte;
    } frame_t;

    // One completed frame waiting for delivery
    typedef struct packed {
        logic                  bank;
        frame_kind_t           kind;
        logic [DESC_LEN_W-1:0] len;
    } desc_t;

    // Write port into the frame store
    typedef struct packed {
        logic                  en;
        logic                  bank;
        logic [DESC_LEN_W-1:0] addr;
        logic [BYTE_W-1:0]     data;
    } store_wr_t;

endpackage

// File: rtl/dmcd_front.sv
// Front end: accepts words, classifies bytes and ticks, fills the frame store
// and queues a descriptor per finished frame. Depends on dmcd_pkg.
`include "dual_mode_command_deframer_defines.svh"

module dmcd_front #(
    parameter int BINARY_FRAME_BYTES = dmcd_pkg::BINARY_FRAME_BYTES_DEF,
    parameter int LINE_BUFFER_BYTES  = dmcd_pkg::LINE_BUFFER_BYTES_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  dmcd_pkg::cfg_index_t                cfg_index,
    input  logic [dmcd_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                accept,
    input  dmcd_pkg::item_t                     item,
    input  logic                                q_full,
    output logic                                q_push,
    output dmcd_pkg::desc_t                     q_desc,
    output dmcd_pkg::store_wr_t                 wr
);
    import dmcd_pkg::*;

    localparam int BANK_DEPTH = (BINARY_FRAME_BYTES > LINE_BUFFER_BYTES - 1) ?
                                BINARY_FRAME_BYTES : LINE_BUFFER_BYTES - 1;
    localparam int LEN_W      = $clog2(BANK_DEPTH + 1);
    localparam logic [LEN_W-1:0] BIN_LEN  = LEN_W'(BINARY_FRAME_BYTES);
    localparam logic [LEN_W-1:0] LINE_MAX = LEN_W'(LINE_BUFFER_BYTES - 1);

    logic [BYTE_W-1:0] packet_id_reg;
    logic [IDLE_W-1:0] idle_ticks_reg;
    logic [LEN_W-1:0]  fill_reg, fill_next;
    logic [LEN_W-1:0]  trim_reg, trim_next;
    logic              binary_reg, binary_next;
    logic              overflow_reg, overflow_next;
    logic              bank_reg, bank_next;
    logic [IDLE_W-1:0] idle_reg, idle_next;
    logic [IDLE_W-1:0] idle_inc;
    logic [LEN_W-1:0]  fill_inc;
    logic              is_eol;

    // Hold the configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            packet_id_reg  <= PACKET_ID_RST;
            idle_ticks_reg <= IDLE_TICKS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_PACKET_ID:  packet_id_reg  <= cfg_data[BYTE_W-1:0];
                CFG_IDLE_TICKS: idle_ticks_reg <= cfg_data[IDLE_W-1:0];
                default:        ;
            endcase
        end
    end

    assign idle_inc = (idle_reg == {IDLE_W{1'b1}}) ? idle_reg : idle_reg + 1'b1;
    assign fill_inc = fill_reg + 1'b1;
    assign is_eol   = (item.rx_byte == CHAR_CR) || (item.rx_byte == CHAR_LF);

    // Classify the word and work out the next frame state
    always_comb
    begin
        fill_next     = fill_reg;
        trim_next     = trim_reg;
        binary_next   = binary_reg;
        overflow_next = overflow_reg;
        idle_next     = idle_reg;
        q_push        = 1'b0;
        q_desc        = '0;
        wr            = '0;
        wr.bank       = bank_reg;
        wr.addr       = DESC_LEN_W'(fill_reg);
        wr.data       = item.rx_byte;

        if (accept)
        begin
            if (item.opcode == OP_TICK)
            begin
                // Count idle ticks; end an open binary frame early
                if (binary_reg)
                begin
                    idle_next = idle_inc;
                    if (idle_inc >= idle_ticks_reg)
                    begin
                        if (trim_reg > LEN_W'(1))
                        begin
                            q_push      = 1'b1;
                            q_desc.kind = KIND_TIMEOUT;
                            q_desc.len  = DESC_LEN_W'(trim_reg);
                        end
                        fill_next     = '0;
                        binary_next   = 1'b0;
                        overflow_next = 1'b0;
                    end
                end
            end
            else if (binary_reg)
            begin
                // Gather a binary byte; track the length without trailing CR/LF
                wr.en     = 1'b1;
                idle_next = '0;
                if (!is_eol)
                    trim_next = fill_inc;
                if (fill_inc == BIN_LEN)
                begin
                    q_push        = 1'b1;
                    q_desc.kind   = KIND_FULL;
                    q_desc.len    = DESC_LEN_W'(BIN_LEN);
                    fill_next     = '0;
                    binary_next   = 1'b0;
                    overflow_next = 1'b0;
                end
                else
                    fill_next = fill_inc;
            end
            else if ((fill_reg == '0) && (item.rx_byte == packet_id_reg))
            begin
                // Open a binary frame with the packet ID as its first byte
                wr.en       = 1'b1;
                binary_next = 1'b1;
                idle_next   = '0;
                fill_next   = LEN_W'(1);
                trim_next   = LEN_W'(1);
            end
            else if (is_eol)
            begin
                // Close the text line
                if (overflow_reg)
                begin
                    q_push      = 1'b1;
                    q_desc.kind = KIND_DISCARD;
                    q_desc.len  = DESC_LEN_W'(1);
                end
                else if (fill_reg != '0)
                begin
                    q_push      = 1'b1;
                    q_desc.kind = KIND_LINE;
                    q_desc.len  = DESC_LEN_W'(fill_reg);
                end
                fill_next     = '0;
                overflow_next = 1'b0;
            end
            else if (!overflow_reg)
            begin
                // Gather a text byte, or flag the line as too long
                if (fill_reg < LINE_MAX)
                begin
                    wr.en     = 1'b1;
                    fill_next = fill_inc;
                end
                else
                    overflow_next = 1'b1;
            end
        end

        q_desc.bank = bank_reg;
        bank_next   = q_push ? ~bank_reg : bank_reg;
    end

    // Advance the frame state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg     <= '0;
            trim_reg     <= '0;
            binary_reg   <= 1'b0;
            overflow_reg <= 1'b0;
            idle_reg     <= '0;
            bank_reg     <= 1'b0;
        end
        else
        begin
            fill_reg     <= fill_next;
            trim_reg     <= trim_next;
            binary_reg   <= binary_next;
            overflow_reg <= overflow_next;
            idle_reg     <= idle_next;
            bank_reg     <= bank_next;
        end
    end

    `DMCD_ASSERT_IMP(a_bin_fill, binary_reg, (fill_reg != '0) && (fill_reg < BIN_LEN), "binary fill out of range")
    `DMCD_ASSERT_NEVER(a_push_full, q_push && q_full, "descriptor pushed into a full queue")
    `DMCD_ASSERT_IMP(a_ovf_text, overflow_reg, !binary_reg && (fill_reg == LINE_MAX), "overflow outside a full text line")

endmodule

// File: rtl/dmcd_queue.sv
// Two-entry descriptor queue between the front and back ends.
// Depends on dmcd_pkg.
module dmcd_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  dmcd_pkg::desc_t  desc_in,
    input  logic             pop,
    output dmcd_pkg::desc_t  head,
    output logic             q_empty,
    output logic             q_full
);
    import dmcd_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    desc_t             slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;

    assign head    = slot_reg[rd_ptr_reg];
    assign q_empty = (count_reg == '0);
    assign q_full  = (count_reg == CNT_W'(QUEUE_DEPTH));

    // Store pushed descriptors
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= desc_in;
    end

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

// File: rtl/dmcd_back.sv
// Back end: holds the two-bank frame store and walks the head frame out one
// word at a time through a registered read and an output register. Depends on dmcd_pkg.
`include "dual_mode_command_deframer_defines.svh"

module dmcd_back #(
    parameter int BINARY_FRAME_BYTES = dmcd_pkg::BINARY_FRAME_BYTES_DEF,
    parameter int LINE_BUFFER_BYTES  = dmcd_pkg::LINE_BUFFER_BYTES_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  dmcd_pkg::store_wr_t  wr,
    input  dmcd_pkg::desc_t      head,
    input  logic                 q_empty,
    output logic                 q_pop,
    input  logic                 pop,
    output logic                 empty,
    output dmcd_pkg::frame_t     frame
);
    import dmcd_pkg::*;

    localparam int BANK_DEPTH = (BINARY_FRAME_BYTES > LINE_BUFFER_BYTES - 1) ?
                                BINARY_FRAME_BYTES : LINE_BUFFER_BYTES - 1;
    localparam int IDX_W      = $clog2(BANK_DEPTH);
    localparam int MEM_DEPTH  = 2 ** (IDX_W + 1);

    logic [BYTE_W-1:0] mem [MEM_DEPTH];
    logic [BYTE_W-1:0] rd_data_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic              rd_pend_reg;
    logic              out_valid_reg;
    frame_t            out_reg;
    frame_kind_t       kind_reg;
    logic [POS_W-1:0]  pos_reg;
    logic              last_reg;
    logic              issue;
    logic              is_last;

    assign is_last = ((DESC_LEN_W'(idx_reg) + DESC_LEN_W'(1)) == head.len);
    assign issue   = !q_empty && !rd_pend_reg && (!out_valid_reg || pop);
    assign q_pop   = issue && is_last;
    assign empty   = !out_valid_reg;
    assign frame   = out_reg;

    // Write gathered bytes; read the next byte of the head frame
    always_ff @(posedge clk)
    begin
        if (wr.en)
            mem[{wr.bank, wr.addr[IDX_W-1:0]}] <= wr.data;
        if (issue)
        begin
            rd_data_reg <= mem[{head.bank, idx_reg}];
            kind_reg    <= head.kind;
            pos_reg     <= POS_W'(idx_reg);
            last_reg    <= is_last;
        end
    end

    // Fill the output register once the read data lands
    always_ff @(posedge clk)
    begin
        if (rd_pend_reg)
        begin
            out_reg.frame_kind    <= kind_reg;
            out_reg.frame_byte    <= (kind_reg == KIND_DISCARD) ? '0 : rd_data_reg;
            out_reg.byte_position <= pos_reg;
            out_reg.last_byte     <= last_reg;
        end
    end

    // Advance the byte index and the output handshake
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rd_pend_reg <= issue;
            if (issue)
                idx_reg <= is_last ? '0 : idx_reg + 1'b1;
            if (rd_pend_reg)
                out_valid_reg <= 1'b1;
            else if (pop && out_valid_reg)
                out_valid_reg <= 1'b0;
        end
    end

    `DMCD_ASSERT_IMP(a_load_free, rd_pend_reg, !out_valid_reg, "read data arrives while the output word is held")
    `DMCD_ASSERT_IMP(a_pop_last, q_pop, issue && !q_empty, "queue popped without a final read")
    `DMCD_ASSERT_NXT(a_pend_fill, issue, out_valid_reg || rd_pend_reg, "issued read lost")

endmodule

// File: rtl/dual_mode_command_deframer.sv
// Top level of the dual-mode command deframer: front end, descriptor queue, back end.
// Depends on dmcd_pkg, dmcd_front, dmcd_queue and dmcd_back.
//
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------------------
//  input    | push / full          | item  (opcode, rx_byte)
//  result   | empty / pop          | frame (frame_kind, frame_byte,
//           |                      |        byte_position, last_byte)
//  config   | cfg_we               | cfg_index, cfg_data
//
// A word is taken whenever push is high and fewer than two finished frames wait.
// Each result passes through the store read, then the output register, and the
// back end starts no new read while one is pending; full is high while two
// finished frames wait in the descriptor queue and the store's two banks.
// Reset clears all control state at once; there is no clearing pass.
// A stalled result holds the back end only; the front keeps taking words until full.
module dual_mode_command_deframer #(
    parameter int BINARY_FRAME_BYTES = dmcd_pkg::BINARY_FRAME_BYTES_DEF,
    parameter int LINE_BUFFER_BYTES  = dmcd_pkg::LINE_BUFFER_BYTES_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    output logic                             full,
    input  dmcd_pkg::item_t                  item,
    output logic                             empty,
    input  logic                             pop,
    output dmcd_pkg::frame_t                 frame,
    input  logic                             cfg_we,
    input  dmcd_pkg::cfg_index_t             cfg_index,
    input  logic [dmcd_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import dmcd_pkg::*;

    logic       accept;
    logic       q_push;
    logic       q_pop;
    logic       q_empty;
    logic       q_full;
    desc_t      q_desc;
    desc_t      head;
    store_wr_t  wr;

    // Take a word when the queue has room
    assign full   = q_full;
    assign accept = push && !q_full;

    dmcd_front #(
        .BINARY_FRAME_BYTES (BINARY_FRAME_BYTES),
        .LINE_BUFFER_BYTES  (LINE_BUFFER_BYTES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .item      (item),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_desc    (q_desc),
        .wr        (wr)
    );

    dmcd_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .desc_in (q_desc),
        .pop     (q_pop),
        .head    (head),
        .q_empty (q_empty),
        .q_full  (q_full)
    );

    dmcd_back #(
        .BINARY_FRAME_BYTES (BINARY_FRAME_BYTES),
        .LINE_BUFFER_BYTES  (LINE_BUFFER_BYTES)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (wr),
        .head    (head),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .pop     (pop),
        .empty   (empty),
        .frame   (frame)
    );

endmodule

// File: dv/tb_top.sv
// Self-checking bench for dual_mode_command_deframer: directed and random words,
// checked word by word against an in-bench deframing predictor.
// Depends on dmcd_pkg and the dual_mode_command_deframer RTL.
module tb_top;

    import dmcd_pkg::*;

    localparam int FRAME_LEN = BINARY_FRAME_BYTES_DEF;
    localparam int LINE_LEN  = LINE_BUFFER_BYTES_DEF;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  push      = 1'b0;
    logic                  full;
    item_t                 item      = '0;
    logic                  empty;
    logic                  pop       = 1'b0;
    frame_t                frame;
    logic                  cfg_we    = 1'b0;
    cfg_index_t            cfg_index = CFG_PACKET_ID;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // Words waiting to be sent and result words still owed by the block
    item_t       words_to_send[$];
    frame_t      bytes_due[$];
    int unsigned words_queued = 0;
    int unsigned words_taken  = 0;
    int unsigned mismatches   = 0;
    bit          sender_steady = 1'b0;
    bit          sink_steady   = 1'b0;

    // Predictor state and its copy of the registers
    logic [7:0]  held [0:FRAME_LEN+LINE_LEN-1];
    int unsigned held_cnt      = 0;
    bit          in_binary     = 1'b0;
    bit          line_overflow = 1'b0;
    int unsigned idle_run      = 0;
    logic [7:0]  cur_packet_id  = PACKET_ID_RST;
    logic [15:0] cur_idle_ticks = IDLE_TICKS_RST;

    dual_mode_command_deframer #(
        .BINARY_FRAME_BYTES (FRAME_LEN),
        .LINE_BUFFER_BYTES  (LINE_LEN)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .empty     (empty),
        .pop       (pop),
        .frame     (frame),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // Queue one result word per held byte, the final one marked
    task automatic deliver(frame_kind_t kind, int unsigned len);
        frame_t f;
        for (int unsigned i = 0; i < len; i++)
        begin
            f.frame_kind    = kind;
            f.frame_byte    = held[i];
            f.byte_position = POS_W'(i);
            f.last_byte     = (i + 1 == len);
            bytes_due.push_back(f);
        end
    endtask

    // End a binary frame; an early end trims trailing CR/LF first
    task automatic close_binary();
        int unsigned len;
        frame_kind_t kind;
        len  = held_cnt;
        kind = KIND_FULL;
        if (len < FRAME_LEN)
        begin
            kind = KIND_TIMEOUT;
            while (len > 1 && (held[len-1] == CHAR_CR || held[len-1] == CHAR_LF))
                len--;
        end
        if (len > 1)
            deliver(kind, len);
        held_cnt      = 0;
        line_overflow = 1'b0;
        in_binary     = 1'b0;
    endtask

    // Advance the predictor by one accepted word
    task automatic deframe_word(item_t w);
        frame_t f;
        if (w.opcode == OP_TICK)
        begin
            if (in_binary)
            begin
                if (idle_run < 16'hFFFF)
                    idle_run++;
                if (idle_run >= cur_idle_ticks)
                    close_binary();
            end
        end
        else if (in_binary)
        begin
            if (held_cnt < FRAME_LEN)
            begin
                held[held_cnt] = w.rx_byte;
                held_cnt++;
                idle_run = 0;
            end
            if (held_cnt >= FRAME_LEN)
                close_binary();
        end
        else if (held_cnt == 0 && w.rx_byte == cur_packet_id)
        begin
            in_binary = 1'b1;
            idle_run  = 0;
            held[0]   = w.rx_byte;
            held_cnt  = 1;
        end
        else if (w.rx_byte == CHAR_CR || w.rx_byte == CHAR_LF)
        begin
            if (line_overflow)
            begin
                f.frame_kind    = KIND_DISCARD;
                f.frame_byte    = '0;
                f.byte_position = '0;
                f.last_byte     = 1'b1;
                bytes_due.push_back(f);
            end
            else if (held_cnt > 0)
                deliver(KIND_LINE, held_cnt);
            held_cnt      = 0;
            line_overflow = 1'b0;
        end
        else if (!line_overflow)
        begin
            if (held_cnt < LINE_LEN - 1)
            begin
                held[held_cnt] = w.rx_byte;
                held_cnt++;
            end
            else
                line_overflow = 1'b1;
        end
    endtask

    // Sender: present queued words, honour full, random gaps between words
    always @(posedge clk)
    begin : sender
        int unsigned send_gap;
        if (!rst_n)
        begin
            push     <= 1'b0;
            send_gap = 0;
        end
        else if (!(push && full))
        begin
            if (push)
            begin
                deframe_word(item);
                words_taken++;
                send_gap = sender_steady ? 0 : $urandom_range(0, 15);
            end
            if (send_gap != 0)
            begin
                send_gap--;
                push <= 1'b0;
            end
            else if (words_to_send.size() != 0)
            begin
                push <= 1'b1;
                item <= words_to_send.pop_front();
            end
            else
                push <= 1'b0;
        end
    end

    // Receiver: check each taken result word, random stalls between words
    always @(posedge clk)
    begin : receiver
        int unsigned take_gap;
        frame_t      want;
        if (!rst_n)
        begin
            pop      <= 1'b0;
            take_gap = 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (bytes_due.size() == 0)
                begin
                    $error("unexpected result word: frame_kind %0d frame_byte 0x%02h",
                           frame.frame_kind, frame.frame_byte);
                    mismatches++;
                end
                else
                begin
                    want = bytes_due.pop_front();
                    if (frame.frame_kind !== want.frame_kind)
                    begin
                        $error("frame_kind: expected %0d, actual %0d",
                               want.frame_kind, frame.frame_kind);
                        mismatches++;
                    end
                    if (frame.frame_byte !== want.frame_byte)
                    begin
                        $error("frame_byte: expected 0x%02h, actual 0x%02h",
                               want.frame_byte, frame.frame_byte);
                        mismatches++;
                    end
                    if (frame.byte_position !== want.byte_position)
                    begin
                        $error("byte_position: expected %0d, actual %0d",
                               want.byte_position, frame.byte_position);
                        mismatches++;
                    end
                    if (frame.last_byte !== want.last_byte)
                    begin
                        $error("last_byte: expected %0d, actual %0d",
                               want.last_byte, frame.last_byte);
                        mismatches++;
                    end
                end
                take_gap = sink_steady ? 0 : $urandom_range(0, 15);
            end
            if (take_gap != 0)
            begin
                take_gap--;
                pop <= 1'b0;
            end
            else
                pop <= 1'b1;
        end
    end

    task automatic queue_word(opcode_t op, logic [7:0] b);
        item_t w;
        w.opcode  = op;
        w.rx_byte = b;
        words_to_send.push_back(w);
        words_queued++;
    endtask

    function automatic logic [7:0] text_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == CHAR_CR || b == CHAR_LF);
        return b;
    endfunction

    // Text line of len bytes; the first byte must not open a binary frame
    task automatic add_line(int unsigned len);
        logic [7:0] b;
        do
            b = text_byte();
        while (b == cur_packet_id);
        queue_word(OP_BYTE, b);
        for (int unsigned i = 1; i < len; i++)
            queue_word(OP_BYTE, text_byte());
        queue_word(OP_BYTE, $urandom_range(0, 1) ? CHAR_CR : CHAR_LF);
    endtask

    // Binary frame of n bytes; a timed frame ends with up to three CR/LF tails and idle ticks
    task automatic add_binary(int unsigned n, bit timed);
        int unsigned trail;
        int unsigned pause_max;
        trail     = (timed && n > 1) ? $urandom_range(0, (n > 4) ? 3 : n - 1) : 0;
        pause_max = (cur_idle_ticks > 4) ? 3 : cur_idle_ticks - 1;
        queue_word(OP_BYTE, cur_packet_id);
        for (int unsigned i = 1; i < n; i++)
        begin
            // Short idle spells that stay below the timeout
            if (cur_idle_ticks >= 2 && $urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, pause_max))
                    queue_word(OP_TICK, 8'($urandom_range(0, 255)));
            if (i >= n - trail)
                queue_word(OP_BYTE, $urandom_range(0, 1) ? CHAR_CR : CHAR_LF);
            else
                queue_word(OP_BYTE, 8'($urandom_range(0, 255)));
        end
        if (timed)
            repeat (((cur_idle_ticks == 0) ? 1 : cur_idle_ticks) + $urandom_range(0, 2))
                queue_word(OP_TICK, 8'($urandom_range(0, 255)));
    endtask

    task automatic write_reg(cfg_index_t idx, logic [15:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_PACKET_ID)
            cur_packet_id = val[7:0];
        else
            cur_idle_ticks = val;
    endtask

    // Wait for every queued word to be taken and every result to arrive
    task automatic settle();
        do
            @(posedge clk);
        while (words_taken != words_queued || bytes_due.size() != 0);
        repeat (20) @(posedge clk);
    endtask

    initial
    begin
        int unsigned goal;
        int unsigned pick;
        int unsigned len;
        bit          paused;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed, reset settings: stray tick, empty line, short line, full frame
        queue_word(OP_TICK, 8'hFF);
        queue_word(OP_BYTE, CHAR_CR);
        queue_word(OP_BYTE, 8'h00);
        queue_word(OP_BYTE, 8'hFF);
        queue_word(OP_BYTE, CHAR_LF);
        queue_word(OP_BYTE, PACKET_ID_RST);
        foreach (held[i])
            if (i < 9)
                queue_word(OP_BYTE, (i == 2) ? CHAR_CR : (i == 3) ? CHAR_LF :
                                    (i == 0) ? 8'h00 : (i == 1) ? 8'hFF : 8'(8'h55 + i));
        settle();

        // Directed, one-tick timeout: trimmed frame, lone packet ID, ID inside a line
        write_reg(CFG_IDLE_TICKS, 16'd1);
        queue_word(OP_BYTE, PACKET_ID_RST);
        queue_word(OP_BYTE, 8'h33);
        queue_word(OP_BYTE, CHAR_CR);
        queue_word(OP_BYTE, CHAR_LF);
        queue_word(OP_TICK, 8'h00);
        queue_word(OP_BYTE, PACKET_ID_RST);
        queue_word(OP_TICK, 8'hA5);
        queue_word(OP_BYTE, 8'h41);
        queue_word(OP_BYTE, PACKET_ID_RST);
        queue_word(OP_BYTE, CHAR_LF);
        settle();

        // Random phases over several register settings
        paused = 1'b0;
        for (int p = 0; p < 5; p++)
        begin
            case (p)
                0:
                begin
                    write_reg(CFG_PACKET_ID, 16'(PACKET_ID_RST));
                    write_reg(CFG_IDLE_TICKS, IDLE_TICKS_RST);
                end
                1:
                begin
                    write_reg(CFG_PACKET_ID, 16'h0000);
                    write_reg(CFG_IDLE_TICKS, 16'd1);
                end
                2:
                begin
                    write_reg(CFG_PACKET_ID, 16'h00FF);
                    write_reg(CFG_IDLE_TICKS, 16'hFFFF);
                end
                3:
                begin
                    write_reg(CFG_PACKET_ID, 16'($urandom_range(0, 255)));
                    write_reg(CFG_IDLE_TICKS, 16'd0);
                end
                default:
                begin
                    write_reg(CFG_PACKET_ID, 16'($urandom_range(0, 255)));
                    write_reg(CFG_IDLE_TICKS, 16'($urandom_range(2, 20)));
                end
            endcase
            // Phase 1 runs without any idling on either side; the others pick at random
            sender_steady = (p == 1) ? 1'b1 : ($urandom_range(0, 2) == 0);
            sink_steady   = (p == 1) ? 1'b1 : ($urandom_range(0, 2) == 0);
            if (p == 0)
            begin
                // Longest line that fits, then one that overflows
                add_line(LINE_LEN - 1);
                add_line(LINE_LEN + 3);
            end
            goal = words_queued + 30;
            while (words_queued < goal)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 35)
                begin
                    len = $urandom_range(0, 9);
                    if (len < 7)
                        len = $urandom_range(1, 12);
                    else if (len < 9)
                        len = $urandom_range(13, LINE_LEN - 2);
                    else
                        len = $urandom_range(LINE_LEN - 4, LINE_LEN + 6);
                    add_line(len);
                end
                else if (pick < 55)
                    add_binary(FRAME_LEN, 1'b0);
                else if (pick < 75)
                begin
                    if (cur_idle_ticks <= 40)
                        add_binary($urandom_range(1, FRAME_LEN - 1), 1'b1);
                    else
                        add_binary(FRAME_LEN, 1'b0);
                end
                else if (pick < 82)
                    queue_word(OP_BYTE, $urandom_range(0, 1) ? CHAR_CR : CHAR_LF);
                else
                begin
                    // Noise: loose bytes and ticks that break sequences up
                    repeat ($urandom_range(1, 3))
                        queue_word(opcode_t'($urandom_range(0, 1)),
                                   8'($urandom_range(0, 255)));
                end
                // Hold the sender once until every owed result has come
                if (p == 3 && !paused && words_queued + 15 >= goal)
                begin
                    settle();
                    paused = 1'b1;
                end
            end
            settle();
        end

        if (mismatches == 0)
            $display("** dual_mode_command_deframer: PASSED **");
        else
            $display("** dual_mode_command_deframer: FAILED **");
        $finish;
    end

    // Guard against a hang
    initial
    begin
        #20_000_000;
        $display("** dual_mode_command_deframer: FAILED **");
        $finish;
    end

endmodule
